>>> rtl/multi_queue_linked_buffer_macros.svh
`ifndef MULTI_QUEUE_LINKED_BUFFER_MACROS_SVH
`define MULTI_QUEUE_LINKED_BUFFER_MACROS_SVH

// same-cycle implication
`define MQLB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MQLB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mqlb_pkg.sv
package mqlb_pkg;

    localparam int SLOTS  = 16;
    localparam int QUEUES = 4;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int QSEL_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(SLOTS);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             link_we;
        logic [IDX_W-1:0] link_waddr;
        logic [PTR_W-1:0] link_wdata;
        logic             data_we;
        logic [IDX_W-1:0] data_waddr;
        logic [31:0]      data_wdata;
    } store_req_t;

    typedef struct packed {
        logic [PTR_W-1:0] link;
        logic [31:0]      data;
    } store_rsp_t;

    // queue number folded into range
    function automatic logic [QSEL_W-1:0] qsel(input logic [1:0] n);
        int v;
        v = int'(n);
        for (int i = 0; i < 3; i++)
        begin
            if (v >= QUEUES)
            begin
                v = v - QUEUES;
            end
        end
        return QSEL_W'(v);
    endfunction

endpackage

>>> rtl/mqlb_req_if.sv
interface mqlb_req_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [1:0]         queue_number;
    logic signed [31:0] push_value;

    modport source (output valid, command, queue_number, push_value, input ready);
    modport sink   (input valid, command, queue_number, push_value, output ready);
endinterface

>>> rtl/mqlb_rsp_if.sv
interface mqlb_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pop_value;
    logic [1:0]         status;

    modport source (output valid, pop_value, status, input ready);
    modport sink   (input valid, pop_value, status, output ready);
endinterface

>>> rtl/multi_queue_linked_buffer.sv
// channel | dir | fields                                | role
// req     | in  | command, queue_number, push_value     | push or pop request
// rsp     | out | pop_value, status                     | one result per request
//
// Per request: S_EXEC, a slot store read (link and data at one address) with the
// first pointer updates, then S_FIN, the rest of them and the result register load.
// Next request is taken in the cycle its predecessor's result is loaded.
// A result waiting on rsp.ready holds S_FIN; req.ready drops then.
// rst_n is asynchronous: free list is slots 0..SLOTS-1 in order, all queues empty.
module multi_queue_linked_buffer (
    input  logic       clk,
    input  logic       rst_n,
    mqlb_req_if.sink   req,
    mqlb_rsp_if.source rsp
);
    import mqlb_pkg::*;
    `include "multi_queue_linked_buffer_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } state_t;

    state_t              state_reg;
    logic                cmd_reg;
    logic [QSEL_W-1:0]   q_reg;
    logic signed [31:0]  val_reg;
    logic [PTR_W-1:0]    free_head_reg;
    logic [PTR_W-1:0]    head_reg [QUEUES];
    logic [PTR_W-1:0]    tail_reg [QUEUES];
    logic [PTR_W-1:0]    sel_reg;
    logic                ok_reg;
    logic                last_reg;
    status_t             st_reg;
    logic                out_valid_reg;
    logic signed [31:0]  pop_value_reg;
    status_t             status_reg;

    store_req_t          sreq;
    store_rsp_t          srsp;

    logic [PTR_W-1:0]    qh;
    logic [PTR_W-1:0]    qt;
    logic                is_push;
    logic [PTR_W-1:0]    sel;
    logic                ok;
    logic                fin_go;
    logic                accept;

    mqlb_slot_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .sreq  (sreq),
        .srsp  (srsp)
    );

    assign qh      = head_reg[q_reg];
    assign qt      = tail_reg[q_reg];
    assign is_push = (cmd_reg == CMD_PUSH);
    assign sel     = is_push ? free_head_reg : qh;
    assign ok      = (sel < NULL_PTR);
    assign fin_go  = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE) || ((state_reg == S_FIN) && fin_go);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        sreq            = '0;
        sreq.rd_idx     = sel[IDX_W-1:0];
        sreq.data_waddr = sel[IDX_W-1:0];
        sreq.data_wdata = val_reg;
        sreq.link_waddr = sel[IDX_W-1:0];
        sreq.link_wdata = free_head_reg;
        if (state_reg == S_EXEC && ok)
        begin
            sreq.rd_en = 1'b1;
            if (is_push)
            begin
                sreq.data_we    = 1'b1;
                sreq.link_waddr = qt[IDX_W-1:0];
                sreq.link_wdata = sel;
                sreq.link_we    = (qh < NULL_PTR) && (qt < NULL_PTR);
            end
            else
            begin
                sreq.link_we = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= NULL_PTR;
                tail_reg[i] <= NULL_PTR;
            end
        end
        else
        begin
            if ((state_reg == S_FIN) && fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_FIN;
                    if (ok)
                    begin
                        if (is_push)
                        begin
                            tail_reg[q_reg] <= sel;
                            if (!(qh < NULL_PTR))
                            begin
                                head_reg[q_reg] <= sel;
                            end
                        end
                        else
                        begin
                            free_head_reg <= sel;
                        end
                    end
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        state_reg <= accept ? S_EXEC : S_IDLE;
                        if (ok_reg)
                        begin
                            if (is_push)
                            begin
                                free_head_reg <= srsp.link;
                            end
                            else
                            begin
                                head_reg[q_reg] <= last_reg ? NULL_PTR : srsp.link;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.command;
            q_reg   <= qsel(req.queue_number);
            val_reg <= req.push_value;
        end
        if (state_reg == S_EXEC)
        begin
            sel_reg  <= sel;
            ok_reg   <= ok;
            last_reg <= (sel == qt);
            st_reg   <= ok ? ST_DONE : (is_push ? ST_FULL : ST_EMPTY);
        end
        if (state_reg == S_FIN && fin_go)
        begin
            pop_value_reg <= (ok_reg && !is_push) ? srsp.data : 32'sd0;
            status_reg    <= st_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.pop_value = pop_value_reg;
    assign rsp.status    = status_reg;

    `MQLB_ASSERT_NOW(a_exec_no_accept, clk, rst_n, state_reg == S_EXEC, !req.ready, "request taken mid-operation")
    `MQLB_ASSERT_NXT(a_fin_hold, clk, rst_n, (state_reg == S_FIN) && !fin_go, (state_reg == S_FIN) && out_valid_reg, "stalled result lost")
    `MQLB_ASSERT_NOW(a_free_head_range, clk, rst_n, 1'b1, free_head_reg <= NULL_PTR, "free head out of range")
    `MQLB_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid_reg && (status_reg != ST_DONE), pop_value_reg == 32'sd0, "failed request carries data")
    `MQLB_ASSERT_NXT(a_pop_frees_slot, clk, rst_n, (state_reg == S_EXEC) && ok && !is_push, free_head_reg == sel_reg, "popped slot not returned to free list")

endmodule

>>> rtl/mqlb_slot_store.sv
module mqlb_slot_store (
    input  logic                clk,
    input  logic                rst_n,
    input  mqlb_pkg::store_req_t sreq,
    output mqlb_pkg::store_rsp_t srsp
);
    import mqlb_pkg::*;

    logic [PTR_W-1:0] link_mem [SLOTS];
    logic [31:0]      data_mem [SLOTS];
    logic [SLOTS-1:0] link_vld_reg;

    logic [PTR_W-1:0] link_rd_reg;
    logic [PTR_W-1:0] fresh_rd_reg;
    logic             vld_rd_reg;
    logic [31:0]      data_rd_reg;

    // unwritten links read as the initial chain i -> i+1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg <= '0;
        end
        else if (sreq.link_we)
        begin
            link_vld_reg[sreq.link_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sreq.link_we)
        begin
            link_mem[sreq.link_waddr] <= sreq.link_wdata;
        end
        if (sreq.data_we)
        begin
            data_mem[sreq.data_waddr] <= sreq.data_wdata;
        end
        if (sreq.rd_en)
        begin
            link_rd_reg  <= link_mem[sreq.rd_idx];
            data_rd_reg  <= data_mem[sreq.rd_idx];
            vld_rd_reg   <= link_vld_reg[sreq.rd_idx];
            fresh_rd_reg <= PTR_W'(sreq.rd_idx) + PTR_W'(1);
        end
    end

    assign srsp.link = vld_rd_reg ? link_rd_reg : fresh_rd_reg;
    assign srsp.data = data_rd_reg;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import mqlb_pkg::*;

    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 90;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 100;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic signed [31:0] pop_value;
        status_t            status;
    } queue_result_t;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  qn;
        logic [31:0] val;
        logic        fixed;
        logic [31:0] fixed_val;
        status_t     fixed_st;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mqlb_req_if req_ch ();
    mqlb_rsp_if rsp_ch ();

    multi_queue_linked_buffer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow of the slot store, queues and free list
    logic [31:0]      slot_value [SLOTS];
    logic [PTR_W-1:0] slot_next  [SLOTS];
    logic [PTR_W-1:0] head_of    [QUEUES];
    logic [PTR_W-1:0] tail_of    [QUEUES];
    logic [PTR_W-1:0] free_top;

    queue_result_t pending_results [$];
    int  mismatches    = 0;
    int  results_taken = 0;
    bit  tx_idle       = 1'b1;
    bit  rx_idle       = 1'b1;

    stim_row_t directed_rows [27] = '{
        '{CMD_POP,  2'd0, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{CMD_POP,  2'd1, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{CMD_POP,  2'd2, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{CMD_POP,  2'd3, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{CMD_PUSH, 2'd1, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd1, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_DONE},
        '{CMD_POP,  2'd1, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_DONE},
        '{CMD_POP,  2'd1, 32'h0000_0000, 1'b1, 32'h8000_0000, ST_DONE},
        '{CMD_POP,  2'd1, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        // queue 1 tail is stale here
        '{CMD_PUSH, 2'd1, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd0, 32'h5555_5555, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd0, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd2, 32'h0F0F_0F0F, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd3, 32'hF0F0_F0F0, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd1, 32'h0000_0001, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd0, 32'h8000_0001, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd2, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd3, 32'h1234_5678, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd0, 32'h00FF_00FF, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd1, 32'hFF00_FF00, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd2, 32'h7FFF_FFFE, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd3, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd0, 32'h3C3C_3C3C, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd1, 32'hC3C3_C3C3, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd2, 32'h6B6B_6B6B, 1'b0, 32'h0000_0000, ST_DONE},
        '{CMD_PUSH, 2'd3, 32'h0BAD_F00D, 1'b1, 32'h0000_0000, ST_FULL},
        '{CMD_POP,  2'd1, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE}
    };

    int push_mix [8] = '{50, 90, 15, 70, 30, 97, 5, 60};

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic queue_result_t queue_op_result(input logic cmd, input logic [1:0] qn,
                                                      input logic [31:0] val);
        queue_result_t r;
        int q;
        int slot;
        r.pop_value = '0;
        r.status    = ST_DONE;
        q = int'(qn) % QUEUES;
        if (cmd == CMD_PUSH)
        begin
            slot = int'(free_top);
            if (slot >= SLOTS)
                r.status = ST_FULL;
            else
            begin
                free_top = slot_next[slot];
                if (int'(head_of[q]) >= SLOTS)
                    head_of[q] = PTR_W'(slot);
                else if (int'(tail_of[q]) < SLOTS)
                    slot_next[tail_of[q]] = PTR_W'(slot);
                slot_next[slot]  = NULL_PTR;
                tail_of[q]       = PTR_W'(slot);
                slot_value[slot] = val;
            end
        end
        else
        begin
            slot = int'(head_of[q]);
            if (slot >= SLOTS)
                r.status = ST_EMPTY;
            else
            begin
                head_of[q]      = slot_next[slot];
                slot_next[slot] = free_top;
                free_top        = PTR_W'(slot);
                r.pop_value     = slot_value[slot];
            end
        end
        return r;
    endfunction

    task automatic offer_request(input stim_row_t row);
        int gap;
        queue_result_t predicted;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= row.cmd;
        req_ch.queue_number <= row.qn;
        req_ch.push_value   <= row.val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = queue_op_result(row.cmd, row.qn, row.val);
        if (row.fixed)
        begin
            predicted.pop_value = row.fixed_val;
            predicted.status    = row.fixed_st;
        end
        pending_results.insert(pending_results.size(), predicted);
    endtask

    initial
    begin
        stim_row_t row;
        int push_pct;
        logic [1:0] focus;
        req_ch.valid        <= 1'b0;
        req_ch.command      <= CMD_PUSH;
        req_ch.queue_number <= 2'd0;
        req_ch.push_value   <= '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_value[i] = '0;
            slot_next[i]  = (i == SLOTS - 1) ? NULL_PTR : PTR_W'(i + 1);
        end
        for (int i = 0; i < QUEUES; i++)
        begin
            head_of[i] = NULL_PTR;
            tail_of[i] = NULL_PTR;
        end
        free_top = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_request(directed_rows[i]);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            push_pct = push_mix[$urandom_range(0, 7)];
            focus    = 2'($urandom_range(0, 3));
            tx_idle  = (phase != 1) && ($urandom_range(0, 3) != 0);
            rx_idle  = (phase != 1) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                row.cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
                row.qn  = ($urandom_range(0, 2) == 0) ? focus : 2'($urandom_range(0, 3));
                case ($urandom_range(0, 15))
                    0:       row.val = 32'h7FFF_FFFF;
                    1:       row.val = 32'h8000_0000;
                    2:       row.val = 32'h0000_0000;
                    3:       row.val = 32'hFFFF_FFFF;
                    default: row.val = $urandom;
                endcase
                row.fixed     = 1'b0;
                row.fixed_val = '0;
                row.fixed_st  = ST_DONE;
                offer_request(row);
            end
        end
        req_ch.valid <= 1'b0;

        for (int c = 0; c < DRAIN_LIMIT && pending_results.size() > 0; c++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int gap;
        queue_result_t want;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            // long back-pressure so the block fills and stalls its input
            if (results_taken == HOLD_AT)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = rx_idle ? $urandom_range(0, 3) : 0;
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            results_taken++;
            if (pending_results.size() == 0)
                report_mismatch("result with no request pending");
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (rsp_ch.pop_value !== want.pop_value)
                    report_mismatch($sformatf("pop_value got %0d, expected %0d",
                                              rsp_ch.pop_value, want.pop_value));
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status got %0d, expected %0d",
                                              rsp_ch.status, want.status));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
